FILE: sv/cle_pkg.sv
`default_nettype none
package cle_pkg;

    localparam logic [8:0] LINE_MAX = 9'd256;
    localparam logic [8:0] CAP_MIN  = 9'd2;

    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_SP  = 8'd32;
    localparam logic [7:0] CH_DEL = 8'd127;

    localparam int unsigned MAX_RES = 4;

    typedef enum logic [1:0] {
        KIND_ECHO  = 2'd0,
        KIND_STORE = 2'd1,
        KIND_DONE  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [8:0]  position;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [2:0]                 count;
        result_t [MAX_RES-1:0]      res;
        logic [8:0]                 next_len;
    } decode_t;

endpackage
`default_nettype wire

FILE: sv/cle_decode.sv
`default_nettype none
module cle_decode
(
    input  wire logic [7:0]     in_char,
    input  wire logic [8:0]     line_len,
    input  wire logic [8:0]     line_cap,
    output cle_pkg::decode_t    dec
);

    logic [8:0] eff_cap;
    logic [8:0] limit;
    logic [8:0] len_inc;
    cle_pkg::result_t blank;

    always_comb
    begin
        if (line_cap < cle_pkg::CAP_MIN)
        begin
            eff_cap = cle_pkg::CAP_MIN;
        end
        else if (line_cap > cle_pkg::LINE_MAX)
        begin
            eff_cap = cle_pkg::LINE_MAX;
        end
        else
        begin
            eff_cap = line_cap;
        end
        limit   = 9'(eff_cap - 9'd1);
        len_inc = 9'(line_len + 9'd1);
    end

    assign blank = '{kind: cle_pkg::KIND_ECHO, data_byte: 8'd0, position: 9'd0, last: 1'b0};

    always_comb
    begin
        dec.count    = 3'd0;
        dec.res      = {cle_pkg::MAX_RES{blank}};
        dec.next_len = line_len;

        if (line_len >= limit)
        begin
            // capacity lowered mid line: drop char, close line
            dec.count  = 3'd1;
            dec.res[0] = '{cle_pkg::KIND_DONE, 8'd0, line_len, 1'b1};
            dec.next_len = 9'd0;
        end
        else if (in_char == cle_pkg::CH_CR || in_char == cle_pkg::CH_LF)
        begin
            dec.count  = 3'd4;
            dec.res[0] = '{cle_pkg::KIND_ECHO, cle_pkg::CH_CR, 9'd0, 1'b0};
            dec.res[1] = '{cle_pkg::KIND_ECHO, cle_pkg::CH_LF, 9'd0, 1'b0};
            dec.res[2] = '{cle_pkg::KIND_STORE, cle_pkg::CH_LF, line_len, 1'b0};
            dec.res[3] = '{cle_pkg::KIND_DONE, 8'd0, len_inc, 1'b1};
            dec.next_len = 9'd0;
        end
        else if (in_char == cle_pkg::CH_DEL || in_char == cle_pkg::CH_BS)
        begin
            if (line_len != 9'd0)
            begin
                dec.count  = 3'd3;
                dec.res[0] = '{cle_pkg::KIND_ECHO, cle_pkg::CH_BS, 9'd0, 1'b0};
                dec.res[1] = '{cle_pkg::KIND_ECHO, cle_pkg::CH_SP, 9'd0, 1'b0};
                dec.res[2] = '{cle_pkg::KIND_ECHO, cle_pkg::CH_BS, 9'd0, 1'b1};
                dec.next_len = 9'(line_len - 9'd1);
            end
        end
        else if (in_char >= cle_pkg::CH_SP && in_char < cle_pkg::CH_DEL)
        begin
            dec.res[0] = '{cle_pkg::KIND_STORE, in_char, line_len, 1'b0};
            if (len_inc >= limit)
            begin
                dec.count  = 3'd3;
                dec.res[1] = '{cle_pkg::KIND_ECHO, in_char, 9'd0, 1'b0};
                dec.res[2] = '{cle_pkg::KIND_DONE, 8'd0, len_inc, 1'b1};
                dec.next_len = 9'd0;
            end
            else
            begin
                dec.count  = 3'd2;
                dec.res[1] = '{cle_pkg::KIND_ECHO, in_char, 9'd0, 1'b1};
                dec.next_len = len_inc;
            end
        end
    end

endmodule
`default_nettype wire

FILE: sv/cle_out_queue.sv
`default_nettype none
module cle_out_queue
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load_valid,
    output logic                    load_ready,
    input  wire cle_pkg::decode_t   dec,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output cle_pkg::result_t        res
);

    cle_pkg::result_t [cle_pkg::MAX_RES-1:0] buf_reg;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       take;
    logic       load;

    assign out_valid  = (cnt_reg != 3'd0);
    assign res        = buf_reg[idx_reg];
    assign take       = out_valid && out_ready;
    assign load_ready = !out_valid || (take && res.last);
    assign load       = load_valid && load_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load)
        begin
            cnt_next = dec.count;
            idx_next = 2'd0;
        end
        else if (take)
        begin
            idx_next = 2'(idx_reg + 2'd1);
            if (res.last)
            begin
                cnt_next = 3'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
            idx_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg <= dec.res;
        end
    end

endmodule
`default_nettype wire

FILE: sv/console_line_editor_unit.sv
// Console line editor. Takes one received character per request on in_*
// and emits echo, store and line-complete results on out_*, one result per
// cycle in order while out_ready is high; last marks the final result of a
// character. A character is registered, decoded combinationally against the
// running line length and dropped into a four-entry result buffer that
// drains one entry per cycle while out_ready is high, so a character holds
// the output until all of its results (0 to 4) are taken. The next
// character is taken while the buffer still drains. line_capacity is written
// through cfg_valid/cfg_ready, always ready, resets to 256 and is clamped
// to 2..256; write it only while the block is idle.
`default_nettype none
module console_line_editor_unit
(
    input  wire logic           clk,
    input  wire logic           rst_n,

    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [8:0]     line_capacity,

    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [7:0]     in_char,

    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [1:0]          kind,
    output logic [7:0]          data_byte,
    output logic [8:0]          position,
    output logic                last
);

    logic [8:0]         cap_reg;
    logic [8:0]         len_reg;
    logic [7:0]         char_reg;
    logic               vld_reg;
    logic               adv;
    logic               q_ready;
    cle_pkg::decode_t   dec;
    cle_pkg::result_t   res;

    assign cfg_ready = 1'b1;
    assign adv       = vld_reg && q_ready;
    assign in_ready  = !vld_reg || q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= cle_pkg::LINE_MAX;
            len_reg <= 9'd0;
            vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= line_capacity;
            end
            if (adv)
            begin
                len_reg <= dec.next_len;
            end
            if (in_valid && in_ready)
            begin
                vld_reg <= 1'b1;
            end
            else if (adv)
            begin
                vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= in_char;
        end
    end

    cle_decode u_decode
    (
        .in_char    (char_reg),
        .line_len   (len_reg),
        .line_cap   (cap_reg),
        .dec        (dec)
    );

    cle_out_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (vld_reg),
        .load_ready (q_ready),
        .dec        (dec),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .res        (res)
    );

    assign kind      = res.kind;
    assign data_byte = res.data_byte;
    assign position  = res.position;
    assign last      = res.last;

endmodule
`default_nettype wire

FILE: tb/console_line_editor_unit_tb.sv
`timescale 1ns / 1ps
module console_line_editor_unit_tb;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned MODE_SPAN      = 25;

    typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } idle_mode_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [8:0] line_capacity = 9'd0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_char = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [8:0] position;
    logic       last;

    // editor state as the block should hold it
    logic [8:0]        capacity = cle_pkg::LINE_MAX;
    logic [8:0]        line_len = 9'd0;
    cle_pkg::result_t  pending_results[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatches = 0;
    int unsigned chars_sent = 0;
    int unsigned results_seen = 0;
    int unsigned cap_writes = 0;
    int unsigned quiet_cycles = 0;

    console_line_editor_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .line_capacity (line_capacity),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_char       (in_char),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .data_byte     (data_byte),
        .position      (position),
        .last          (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic cle_pkg::result_t make_result(input cle_pkg::kind_t k,
                                                     input logic [7:0] d,
                                                     input logic [8:0] p);
        cle_pkg::result_t r;
        r.kind      = k;
        r.data_byte = d;
        r.position  = p;
        r.last      = 1'b0;
        return r;
    endfunction

    // expected results of one accepted character, in output order
    function automatic void edit_char(input logic [7:0] ch);
        logic [8:0]       eff_cap;
        logic [8:0]       end_len;
        cle_pkg::result_t res[cle_pkg::MAX_RES];
        int               n;
        eff_cap = (capacity < cle_pkg::CAP_MIN) ? cle_pkg::CAP_MIN :
                  ((capacity > cle_pkg::LINE_MAX) ? cle_pkg::LINE_MAX : capacity);
        end_len = eff_cap - 9'd1;
        n = 0;
        if (line_len >= end_len)
        begin
            // capacity lowered mid line: drop the char, close the line
            res[n] = make_result(cle_pkg::KIND_DONE, 8'd0, line_len);
            n++;
            line_len = 9'd0;
        end
        else if (ch == cle_pkg::CH_CR || ch == cle_pkg::CH_LF)
        begin
            res[0] = make_result(cle_pkg::KIND_ECHO, cle_pkg::CH_CR, 9'd0);
            res[1] = make_result(cle_pkg::KIND_ECHO, cle_pkg::CH_LF, 9'd0);
            res[2] = make_result(cle_pkg::KIND_STORE, cle_pkg::CH_LF, line_len);
            line_len = line_len + 9'd1;
            res[3] = make_result(cle_pkg::KIND_DONE, 8'd0, line_len);
            n = 4;
            line_len = 9'd0;
        end
        else if (ch == cle_pkg::CH_DEL || ch == cle_pkg::CH_BS)
        begin
            if (line_len != 9'd0)
            begin
                line_len = line_len - 9'd1;
                res[0] = make_result(cle_pkg::KIND_ECHO, cle_pkg::CH_BS, 9'd0);
                res[1] = make_result(cle_pkg::KIND_ECHO, cle_pkg::CH_SP, 9'd0);
                res[2] = make_result(cle_pkg::KIND_ECHO, cle_pkg::CH_BS, 9'd0);
                n = 3;
            end
        end
        else if (ch >= cle_pkg::CH_SP && ch < cle_pkg::CH_DEL)
        begin
            res[0] = make_result(cle_pkg::KIND_STORE, ch, line_len);
            res[1] = make_result(cle_pkg::KIND_ECHO, ch, 9'd0);
            n = 2;
            line_len = line_len + 9'd1;
            if (line_len >= end_len)
            begin
                res[2] = make_result(cle_pkg::KIND_DONE, 8'd0, line_len);
                n = 3;
                line_len = 9'd0;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1)
                res[i].last = 1'b1;
            pending_results.push_back(res[i]);
        end
    endfunction

    always @(posedge clk)
    begin : check_result
        cle_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: kind %0d data_byte %0d position %0d last %0d",
                       kind, data_byte, position, last);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, kind);
                    mismatches++;
                end
                if (data_byte !== want.data_byte)
                begin
                    $error("data_byte: expected %0d, got %0d", want.data_byte, data_byte);
                    mismatches++;
                end
                if (position !== want.position)
                begin
                    $error("position: expected %0d, got %0d", want.position, position);
                    mismatches++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("console_line_editor_unit_tb: FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic void set_idle_mode(input idle_mode_t m);
        case (m)
            IDLE_SEND: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            IDLE_BOTH: begin send_idle_pct = 38; recv_stall_pct = 38; end
            default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endfunction

    // all tasks start and end just after a falling edge
    task automatic send_char(input logic [7:0] ch);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        in_valid = 1'b1;
        in_char  = ch;
        do
            @(posedge clk);
        while (!in_ready);
        edit_char(ch);
        chars_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [8:0] value);
        wait_drained();
        cfg_valid     = 1'b1;
        line_capacity = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        capacity = value;
        cap_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [7:0] pick_char(input bit long_line);
        int unsigned r;
        r = $urandom_range(99);
        if (long_line)
        begin
            if (r < 98)
                return 8'($urandom_range(126, 32));
            return r[0] ? cle_pkg::CH_DEL : cle_pkg::CH_BS;
        end
        if (r < 60)
            return 8'($urandom_range(126, 32));
        if (r < 65)
            return cle_pkg::CH_CR;
        if (r < 70)
            return cle_pkg::CH_LF;
        if (r < 76)
            return cle_pkg::CH_BS;
        if (r < 82)
            return cle_pkg::CH_DEL;
        return 8'($urandom_range(255));
    endfunction

    task automatic test_printable();
        send_char(cle_pkg::CH_SP);
        send_char(8'd126);
        send_char("A");
    endtask

    task automatic test_rubout();
        send_char(cle_pkg::CH_BS);
        send_char(cle_pkg::CH_DEL);
        send_char(cle_pkg::CH_DEL);
        send_char(cle_pkg::CH_BS);
    endtask

    task automatic test_line_end();
        send_char("x");
        send_char(cle_pkg::CH_CR);
        send_char(cle_pkg::CH_LF);
    endtask

    task automatic test_ignored();
        send_char(8'd0);
        send_char(8'd31);
        send_char(8'd128);
        send_char(8'd255);
        send_char(8'd9);
    endtask

    task automatic test_capacity_clamp();
        write_capacity(9'd2);
        send_char("a");
        send_char(cle_pkg::CH_CR);
        write_capacity(9'd0);
        send_char("b");
        write_capacity(9'd1);
        send_char("c");
        write_capacity(9'd511);
        send_char("d");
    endtask

    task automatic test_stale_length();
        send_char("e");
        send_char("f");
        send_char("g");
        send_char("h");
        write_capacity(9'd3);
        send_char("z");
        send_char("z");
        send_char("y");
    endtask

    task automatic test_random();
        int unsigned n_items;
        logic [8:0]  cap;
        bit          long_line;
        int unsigned idx;
        idx = 0;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin cap = 9'd5;   n_items = 30;  long_line = 1'b0; end
                1: begin cap = 9'd256; n_items = 290; long_line = 1'b1; end
                2: begin cap = 9'd17;  n_items = 30;  long_line = 1'b0; end
                3: begin cap = 9'd3;   n_items = 20;  long_line = 1'b0; end
                default: begin cap = 9'd300; n_items = 20; long_line = 1'b0; end
            endcase
            write_capacity(cap);
            for (int i = 0; i < n_items; i++)
            begin
                set_idle_mode(idle_mode_t'((idx / MODE_SPAN) % 4));
                idx++;
                // hold off until every result so far is out
                if ($urandom_range(39) == 0)
                    wait_drained();
                send_char(pick_char(long_line));
            end
        end
        set_idle_mode(IDLE_NONE);
    endtask

    initial
    begin
        set_idle_mode(IDLE_NONE);
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_printable();
        test_rubout();
        test_line_end();
        test_ignored();
        test_capacity_clamp();
        test_stale_length();
        test_random();
        wait_drained();
        $display("console_line_editor_unit_tb: %0d characters, %0d results, %0d capacity writes",
                 chars_sent, results_seen, cap_writes);
        $display("%s%s", "console_line_editor_unit_tb: rubout, line end, clamped and lowered ",
                 "capacity, idle and stall patterns");
        if (mismatches == 0)
            $display("console_line_editor_unit_tb: PASS");
        else
            $display("console_line_editor_unit_tb: FAIL");
        $finish;
    end

endmodule
